>>> rtl/core/tdp_pkg.sv
// Package for the trial-division primality tester.
// Holds the fixed field width, the trial-division constants and the divider status type.
package tdp_pkg;

  localparam int CAND_W     = 32;
  localparam int FIRST_DIV  = 5;
  localparam int FIRST_SQ   = 25;
  localparam int DIV_STEP   = 6;
  localparam int PAIR_GAP   = 2;
  localparam int SMALL_DIV  = 3;
  localparam int SQ_STEP_K  = 36;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

>>> rtl/core/tdp_if.sv
// Channel interfaces for the primality tester: candidate in, verdict out.
// Depends on tdp_pkg for the candidate width.
interface tdp_in_if import tdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

>>> rtl/core/tdp_div.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on tdp_pkg for the status struct.
module tdp_div import tdp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output div_stat_t              stat
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] q_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] div_r;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic [VALUE_WIDTH-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, q_r[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[VALUE_WIDTH-1:0];
    end else begin
      rem_nxt = trial[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_WIDTH);
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

>>> rtl/core/trial_division_primality_test_top.sv
// Trial-division primality tester, 6k +/- 1 divisors, top level with sequencer.
// Depends on tdp_pkg, tdp_if (channels) and tdp_div (shared remainder unit).
//
// Usage:
//   in_ch  : valid/ready word carrying candidate; only the low VALUE_WIDTH bits count.
//   out_ch : valid/ready word carrying is_prime, one per candidate, in order.
// One candidate is worked on at a time; in_ch.ready is high only while idle.
// Each remainder is worked out in the shared divider; the loop runs two
// remainders per divisor pair d, d+2 while d*d <= n, with d*d kept
// incrementally by one update per pair. Values 0..3 and even values are
// decided without the divider, other multiples of three after one remainder,
// and primes only once d*d exceeds n. A new candidate is taken only after
// the last one's verdict has left the sequencer for the output register.
// The verdict sits in an output register; a new candidate is taken while it
// waits, and a finished verdict is held internally until out_ch.ready frees it.
// Reset (synchronous, rst_n low) drops any candidate in flight and any
// pending verdict.
module trial_division_primality_test_top import tdp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  tdp_in_if.sink    in_ch,
  tdp_out_if.source out_ch
);

  localparam int SQ_W = VALUE_WIDTH + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT3,
    S_BOUND,
    S_WAITA,
    S_WAITB,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SQ_W-1:0]        sq_nxt;
  logic [VALUE_WIDTH-1:0] divisor_r;
  logic                   start_r;
  logic                   res_r;
  logic                   out_valid_r;
  logic                   out_prime_r;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] cand_n;
  div_stat_t              dstat;

  generate
    if (VALUE_WIDTH >= CAND_W) begin : g_ext
      assign cand_n = VALUE_WIDTH'(in_ch.candidate);
    end else begin : g_trunc
      assign cand_n = in_ch.candidate[VALUE_WIDTH-1:0];
    end
  endgenerate

  // (d+6)^2 = d^2 + 12d + 36
  assign sq_nxt = sq_r + SQ_W'({d_r, 3'b000}) + SQ_W'({d_r, 2'b00}) + SQ_W'(SQ_STEP_K);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  tdp_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (n_r),
    .divisor  (divisor_r),
    .stat     (dstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            n_r     <= cand_n;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_r <= VALUE_WIDTH'(1)) begin
            res_r   <= 1'b0;
            state_r <= S_OUT;
          end else if (n_r <= VALUE_WIDTH'(SMALL_DIV)) begin
            res_r   <= 1'b1;
            state_r <= S_OUT;
          end else if (!n_r[0]) begin
            res_r   <= 1'b0;
            state_r <= S_OUT;
          end else begin
            divisor_r <= VALUE_WIDTH'(SMALL_DIV);
            start_r   <= 1'b1;
            state_r   <= S_WAIT3;
          end
        end
        S_WAIT3: begin
          if (dstat.done) begin
            if (dstat.rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              d_r     <= VALUE_WIDTH'(FIRST_DIV);
              sq_r    <= SQ_W'(FIRST_SQ);
              state_r <= S_BOUND;
            end
          end
        end
        S_BOUND: begin
          if (sq_r > SQ_W'(n_r)) begin
            res_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            divisor_r <= d_r;
            start_r   <= 1'b1;
            state_r   <= S_WAITA;
          end
        end
        S_WAITA: begin
          if (dstat.done) begin
            if (dstat.rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              divisor_r <= d_r + VALUE_WIDTH'(PAIR_GAP);
              start_r   <= 1'b1;
              state_r   <= S_WAITB;
            end
          end
        end
        S_WAITB: begin
          if (dstat.done) begin
            if (dstat.rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              d_r     <= d_r + VALUE_WIDTH'(DIV_STEP);
              sq_r    <= sq_nxt;
              state_r <= S_BOUND;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_prime_r <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_prime = out_prime_r;

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !dstat.busy)
    else $error("divider busy while taking a new word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word taken while one is in flight");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> (state_r == S_WAIT3 || state_r == S_WAITA || state_r == S_WAITB))
    else $error("remainder finished outside a wait state");

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !dstat.busy)
    else $error("divider restarted while busy");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for trial_division_primality_test_top: a queue-fed driver and a monitor
// that checks each verdict against a local trial-division predictor.
// Depends on tdp_pkg, tdp_if and the top level under rtl/core.
module testbench;
  import tdp_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int CALM_FROM    = 45;
  localparam int CALM_TO      = 75;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_LEN     = 400;
  localparam int RANDOM_WORDS = 76;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 4_000_000;

  logic clk;
  logic rst_n;

  tdp_in_if  in_ch ();
  tdp_out_if out_ch ();

  trial_division_primality_test_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [CAND_W-1:0] pending[$];
  bit                verdicts_due[$];
  int                accepted_cnt;
  int                errors = 0;
  int                hold_left;
  bit                hold_done;
  int                cycles;

  function automatic bit prime_verdict(logic [CAND_W-1:0] word);
    longint unsigned n;
    longint unsigned d;
    n = word;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (d = 5; d * d <= n; d += 6) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly cheap values; full-width ones carry a small factor so the loop exits early
  function automatic logic [CAND_W-1:0] pick_candidate();
    logic [CAND_W-1:0] p;
    logic [CAND_W-1:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 4095);
      4: return $urandom_range(4096, 32'h0010_0000);
      5, 6: return $urandom & ~32'd1;
      7: return $urandom_range(0, 32'h5555_5555) * 3;
      8: begin
        case ($urandom_range(0, 4))
          0: p = 5;
          1: p = 7;
          2: p = 11;
          3: p = 13;
          default: p = 37;
        endcase
        return $urandom_range(1, 32'hFFFF_FFFF / p) * p;
      end
      default: begin
        p = $urandom_range(2, 127) * 2 + 1;
        q = $urandom_range(2, 32767) * 2 + 1;
        return p * q;
      end
    endcase
  endfunction

  function automatic bit calm();
    return accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("trial_division_primality_test_top: mismatch");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.candidate <= '0;
      accepted_cnt    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdicts_due.push_back(prime_verdict(in_ch.candidate));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid     <= 1'b1;
          in_ch.candidate <= pending.pop_front();
        end else begin
          in_ch.valid     <= 1'b0;
          in_ch.candidate <= $urandom;
        end
      end
    end
  end

  // monitor, with one long hold-off so the block backs up
  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: is_prime expected none, got %0b", $time, out_ch.is_prime);
        end else begin
          want = verdicts_due.pop_front();
          if (want !== out_ch.is_prime) begin
            errors++;
            $display("%0t: is_prime expected %0b, got %0b", $time, want, out_ch.is_prime);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm() || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // edge values, small squares, d and d+2 factors, largest 32-bit prime
    pending = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd35,
                32'd49, 32'd121, 32'd143, 32'd169, 32'd289, 32'd323, 32'd65521, 32'd65535,
                32'd1000003, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4294967291};
    while (pending.size() != 0 || in_ch.valid || verdicts_due.size() != 0) @(negedge clk);

    // sender paused until drained; now the random words
    repeat (RANDOM_WORDS) pending.push_back(pick_candidate());
    while (pending.size() != 0 || in_ch.valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("trial_division_primality_test_top: match");
    end else begin
      $display("trial_division_primality_test_top: mismatch");
    end
    $finish;
  end

endmodule
